### rtl/core/bmi_pkg.sv
// Package for the binary modular inverse unit: sizes, datapath operation codes and the
// command and status structures passed between the controller and the datapath.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bmi_pkg;

  localparam int NUM_WORDS = 4;
  localparam int WORD_W    = 64;
  localparam int BIG_W     = NUM_WORDS * WORD_W;
  localparam int IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CNT_W     = $clog2(NUM_WORDS + 1);
  localparam int MAX_ITER  = 128 * NUM_WORDS;
  localparam int ITER_W    = $clog2(MAX_ITER + 1);

  localparam int NUM_CFG   = 4;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = $clog2(NUM_CFG);
  localparam int ADDR_W    = CFG_IDX_W + 3;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_INIT_ZERO,
    DP_INIT_RUN,
    DP_HALVE_A,
    DP_HALVE_B,
    DP_SUB_A,
    DP_SUB_B,
    DP_FIX,
    DP_HALVE_U,
    DP_HALVE_V,
    DP_SHIFT_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t               op;
    logic                 ld_store;
    logic [IDX_W-1:0]     ld_idx;
    logic [NUM_WORDS-1:0] clr_mask;
  } dp_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic a_eq_b;
    logic a_lt_b;
    logic a_odd;
    logic b_odd;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/bmi_datapath.sv
// Datapath of the binary modular inverse unit: the value registers a and b, the
// coefficient registers u and v and a scratch word, with coefficient subtractors in both
// orders and one shared halver. Depends on bmi_pkg; driven by bmi_ctrl through a command.
`timescale 1ns / 1ps
`default_nettype none

module bmi_datapath (
  input  logic                          clk,
  input  bmi_pkg::dp_cmd_t              cmd,
  input  logic [bmi_pkg::WORD_W-1:0]    in_word,
  input  logic [bmi_pkg::BIG_W-1:0]     modulus,
  output bmi_pkg::dp_stat_t             stat,
  output logic [bmi_pkg::WORD_W-1:0]    out_word
);
  import bmi_pkg::*;

  logic [BIG_W-1:0] a;
  logic [BIG_W-1:0] b;
  logic [BIG_W-1:0] u;
  logic [BIG_W-1:0] v;
  logic [BIG_W-1:0] w;
  logic             brw;

  logic [BIG_W:0]   diff_ab;
  logic [BIG_W:0]   diff_ba;
  logic [BIG_W:0]   csub_uv;
  logic [BIG_W:0]   csub_vu;
  logic [BIG_W-1:0] fix_sum;
  logic [BIG_W-1:0] half_src;
  logic [BIG_W:0]   half_sum;
  logic [BIG_W-1:0] half;

  assign diff_ab = {1'b0, a} - {1'b0, b};
  assign diff_ba = {1'b0, b} - {1'b0, a};

  // Coefficient differences in both orders, so that the choice made from the value
  // comparison only steers a multiplexer; the borrow says the modulus must be added back.
  assign csub_uv = {1'b0, u} - {1'b0, v};
  assign csub_vu = {1'b0, v} - {1'b0, u};

  assign fix_sum = w + modulus;

  // Halving modulo m: an odd coefficient has m added, and the carry becomes the top bit.
  always_comb begin
    if (cmd.op == DP_HALVE_A) begin
      half_src = u;
    end else if (cmd.op == DP_HALVE_B) begin
      half_src = v;
    end else begin
      half_src = w;
    end
    half_sum = half_src[0] ? ({1'b0, half_src} + {1'b0, modulus}) : {1'b0, half_src};
    half     = half_sum[BIG_W:1];
  end

  assign stat.a_zero = ~|a;
  assign stat.a_eq_b = (a == b);
  assign stat.a_lt_b = diff_ab[BIG_W];
  assign stat.a_odd  = a[0];
  assign stat.b_odd  = b[0];

  assign out_word = u[WORD_W-1:0];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        for (int k = 0; k < NUM_WORDS; k++) begin
          if (cmd.ld_store && (cmd.ld_idx == IDX_W'(k))) begin
            a[k*WORD_W +: WORD_W] <= in_word;
          end else if (cmd.clr_mask[k]) begin
            a[k*WORD_W +: WORD_W] <= '0;
          end
        end
      end
      DP_INIT_ZERO: begin
        u <= '0;
      end
      DP_INIT_RUN: begin
        b <= modulus;
        u <= BIG_W'(1);
        v <= '0;
      end
      DP_HALVE_A: begin
        a <= a >> 1;
        u <= half;
      end
      DP_HALVE_B: begin
        b <= b >> 1;
        v <= half;
      end
      DP_SUB_A: begin
        a        <= {1'b0, diff_ab[BIG_W-1:1]};
        {brw, w} <= csub_uv;
      end
      DP_SUB_B: begin
        b        <= {1'b0, diff_ba[BIG_W-1:1]};
        {brw, w} <= csub_vu;
      end
      DP_FIX: begin
        if (brw) begin
          w <= fix_sum;
        end
      end
      DP_HALVE_U: begin
        u <= half;
      end
      DP_HALVE_V: begin
        v <= half;
      end
      DP_SHIFT_OUT: begin
        u <= u >> WORD_W;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/bmi_ctrl.sv
// Controller of the binary modular inverse unit: word gathering, the iteration sequence
// and the result handshake. Depends on bmi_pkg; issues commands to bmi_datapath.
`timescale 1ns / 1ps
`default_nettype none

module bmi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_stall,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                out_last,
  input  bmi_pkg::dp_stat_t   stat,
  output bmi_pkg::dp_cmd_t    cmd
);
  import bmi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ITER,
    ST_FIX,
    ST_HALVE,
    ST_OUT
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);

  state_t            state;
  logic [CNT_W-1:0]  load_count;
  logic [CNT_W-1:0]  count_after;
  logic [ITER_W-1:0] iter_cnt;
  logic [IDX_W-1:0]  out_cnt;
  logic [IDX_W-1:0]  out_cnt_inc;
  logic              coef_sel_v;
  logic              iter_done;

  assign in_stall    = (state != ST_IDLE);
  assign iter_done   = (iter_cnt == ITER_W'(MAX_ITER)) || stat.a_eq_b;
  assign out_cnt_inc = out_cnt + IDX_W'(1);

  always_comb begin
    cmd.op       = DP_NOP;
    cmd.ld_store = (load_count < CNT_W'(NUM_WORDS));
    cmd.ld_idx   = load_count[IDX_W-1:0];
    count_after  = load_count + CNT_W'(cmd.ld_store);
    for (int k = 0; k < NUM_WORDS; k++) begin
      cmd.clr_mask[k] = in_last && (CNT_W'(k) >= count_after);
    end
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LOAD;
        end
      end
      ST_INIT: begin
        cmd.op = stat.a_zero ? DP_INIT_ZERO : DP_INIT_RUN;
      end
      ST_ITER: begin
        if (!iter_done) begin
          priority if (!stat.a_odd) begin
            cmd.op = DP_HALVE_A;
          end else if (!stat.b_odd) begin
            cmd.op = DP_HALVE_B;
          end else if (!stat.a_lt_b) begin
            cmd.op = DP_SUB_A;
          end else begin
            cmd.op = DP_SUB_B;
          end
        end
      end
      ST_FIX: begin
        cmd.op = DP_FIX;
      end
      ST_HALVE: begin
        cmd.op = coef_sel_v ? DP_HALVE_V : DP_HALVE_U;
      end
      ST_OUT: begin
        if (!out_stall) begin
          cmd.op = DP_SHIFT_OUT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      load_count <= '0;
      iter_cnt   <= '0;
      out_cnt    <= '0;
      coef_sel_v <= 1'b0;
      out_valid  <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            load_count <= count_after;
            if (in_last) begin
              state <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          iter_cnt <= '0;
          if (stat.a_zero) begin
            state     <= ST_OUT;
            out_cnt   <= '0;
            out_valid <= 1'b1;
            out_last  <= (LAST_IDX == '0);
          end else begin
            state <= ST_ITER;
          end
        end
        ST_ITER: begin
          if (iter_done) begin
            state     <= ST_OUT;
            out_cnt   <= '0;
            out_valid <= 1'b1;
            out_last  <= (LAST_IDX == '0);
          end else begin
            iter_cnt <= iter_cnt + ITER_W'(1);
            if (stat.a_odd && stat.b_odd) begin
              state      <= ST_FIX;
              coef_sel_v <= stat.a_lt_b;
            end
          end
        end
        ST_FIX: begin
          state <= ST_HALVE;
        end
        ST_HALVE: begin
          state <= ST_ITER;
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (out_cnt == LAST_IDX) begin
              state      <= ST_IDLE;
              out_valid  <= 1'b0;
              out_last   <= 1'b0;
              load_count <= '0;
            end else begin
              out_cnt  <= out_cnt_inc;
              out_last <= (out_cnt_inc == LAST_IDX);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OUT))
    else $error("result valid outside the output phase");

  a_last_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_cnt == LAST_IDX)))
    else $error("last flag does not match the result word count");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    iter_cnt <= ITER_W'(MAX_ITER))
    else $error("iteration count passed its bound");

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= CNT_W'(NUM_WORDS))
    else $error("more words gathered than the operand holds");

  a_fix_then_halve: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX) |=> (state == ST_HALVE))
    else $error("coefficient correction not followed by halving");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_last) |=> (!out_valid && (load_count == '0)))
    else $error("unit did not return to idle after the last result word");
`endif

endmodule

`default_nettype wire

### rtl/core/binary_modular_inverse_unit.sv
// Top level of the binary modular inverse unit: configuration registers on an APB-style
// port, with the controller and datapath. Depends on bmi_pkg, bmi_ctrl and bmi_datapath.
//
//   Channel   Direction  Handshake           Payload
//   cfg       in         psel/penable/pready pwrite, paddr, pwdata, prdata
//   in        in         in_valid/in_stall   in_word (64), in_last (1)
//   out       out        out_valid/out_stall out_word (64), out_last (1)
//
// Operand words are taken while idle; the word flagged last starts the inverse.
// After a set-up step, each iteration either halves a value or subtracts, with the
// coefficient path running its subtract, correction and halving as three separate steps;
// a final step sees a equal b or the iteration count at its bound of 512. A zero operand
// skips the iterations and goes from set-up straight to the first result word.
// The four result words then leave one per accepted request, least significant first.
// Reset is synchronous and active high; it clears the modulus to zero and the controller.
// in_stall is high from the flagged word until the last result request has been taken.
`timescale 1ns / 1ps
`default_nettype none

module binary_modular_inverse_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmi_pkg::ADDR_W-1:0]    paddr,
  input  logic [bmi_pkg::CFG_W-1:0]     pwdata,
  output logic [bmi_pkg::CFG_W-1:0]     prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bmi_pkg::WORD_W-1:0]    in_word,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bmi_pkg::WORD_W-1:0]    out_word,
  output logic                          out_last
);
  import bmi_pkg::*;

  // The modulus words sit at byte addresses 0, 8, 16 and 24.
  logic [CFG_W-1:0]     mod_reg [NUM_CFG];
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_write;
  logic [BIG_W-1:0]     modulus;
  dp_cmd_t              cmd;
  dp_stat_t             stat;

  assign pready    = 1'b1;
  assign cfg_idx   = paddr[ADDR_W-1:3];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = mod_reg[cfg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CFG; k++) begin
        mod_reg[k] <= '0;
      end
    end else if (cfg_write) begin
      mod_reg[cfg_idx] <= pwdata;
    end
  end

  // Only the first NUM_WORDS registers form the modulus.
  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      modulus[k*WORD_W +: WORD_W] = mod_reg[k][WORD_W-1:0];
    end
  end

  bmi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_last  (out_last),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmi_datapath u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .in_word  (in_word),
    .modulus  (modulus),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

### tb/sv/binary_modular_inverse_unit_test.sv
// Self-checking testbench for binary_modular_inverse_unit: drives operand words and
// modulus registers, predicts or looks up each inverse and checks every result word.
// Depends on bmi_pkg and the binary_modular_inverse_unit RTL; reads no files.
`timescale 1ns / 1ps

module binary_modular_inverse_unit_test;
  import bmi_pkg::*;

  typedef logic [BIG_W-1:0] big_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } result_word_t;

  // One row of the directed table. When set_mod is high the modulus registers are
  // rewritten (with the block idle) before the word is offered. When typed is high the
  // inverse in the row is the one checked, rather than the predicted one.
  typedef struct packed {
    logic              set_mod;
    big_t              mod_value;
    logic [WORD_W-1:0] word;
    logic              last;
    logic              typed;
    big_t              inverse;
  } dir_row_t;

  localparam logic [WORD_W-1:0] TOP_WORD_BIT = 64'h8000_0000_0000_0000;
  localparam logic [WORD_W-1:0] FULL_WORD    = 64'hffff_ffff_ffff_ffff;
  localparam big_t NO_BIG    = 256'd0;
  localparam big_t BIG_ONE   = 256'd1;
  localparam big_t ALL_ONES  = {BIG_W{1'b1}};
  localparam big_t MOD_THREE = 256'd3;
  localparam big_t MOD_EVEN  = {64'h0, 64'h0000_0000_dead_beef,
                                64'h0123_4567_89ab_cdef, 64'h0000_0000_0000_1000};
  // The inverse of two modulo 2^256-1 is 2^255: the odd coefficient plus the modulus
  // carries out of the top word, and that carry must land in the top bit.
  localparam big_t INV_TWO   = {TOP_WORD_BIT, 192'd0};

  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 64;
  localparam int LONG_HOLD     = 2000;
  localparam int SEG_WORDS     = 28;
  localparam int DIR_ROWS      = 23;

  localparam dir_row_t dir_table [DIR_ROWS] = '{
    // Modulus still zero from reset: a zero operand gives zero, and operand one runs
    // into the iteration bound with u still one.
    '{1'b0, NO_BIG,   64'd0,                  1'b1, 1'b1, NO_BIG},
    '{1'b0, NO_BIG,   64'd1,                  1'b1, 1'b1, BIG_ONE},
    // Largest modulus: carry into the top bit, the inverse of one, and modulus minus one.
    '{1'b1, ALL_ONES, 64'd2,                  1'b1, 1'b1, INV_TWO},
    '{1'b0, NO_BIG,   64'd1,                  1'b1, 1'b1, BIG_ONE},
    '{1'b0, NO_BIG,   64'hffff_ffff_ffff_fffe, 1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   FULL_WORD,              1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   FULL_WORD,              1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   FULL_WORD,              1'b1, 1'b0, NO_BIG},
    // Too many words: the fifth is dropped, and the flagged sixth is dropped but still
    // starts the work.
    '{1'b0, NO_BIG,   64'h0123_4567_89ab_cdef, 1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   64'h0f1e_2d3c_4b5a_6978, 1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   64'h1111_1111_1111_1111, 1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   64'hdead_beef_0bad_f00d, 1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   64'hcafe_f00d_1234_5678, 1'b1, 1'b0, NO_BIG},
    // Short operand: the two missing high words count as zero.
    '{1'b0, NO_BIG,   64'h0123_4567_89ab_cdef, 1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   64'hfedc_ba98_7654_3210, 1'b1, 1'b0, NO_BIG},
    // A zero operand spread over two words still gives zero.
    '{1'b0, NO_BIG,   64'd0,                  1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   64'd0,                  1'b1, 1'b1, NO_BIG},
    // Smallest useful odd modulus.
    '{1'b1, MOD_THREE, 64'd2,                 1'b1, 1'b0, NO_BIG},
    // Even modulus, with an all-ones operand that is far above it.
    '{1'b1, MOD_EVEN, FULL_WORD,              1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   FULL_WORD,              1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   FULL_WORD,              1'b0, 1'b0, NO_BIG},
    '{1'b0, NO_BIG,   FULL_WORD,              1'b1, 1'b0, NO_BIG}
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [CFG_W-1:0]  pwdata;
  logic [CFG_W-1:0]  prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [WORD_W-1:0] in_word;
  logic              in_last;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] out_word;
  logic              out_last;

  // Travels with the payload so that the checker knows whether the request on offer
  // carries a typed-in inverse.
  logic offer_typed;
  big_t offer_inverse;

  // The predictor's own copy of the modulus registers and of the operand being gathered.
  logic [CFG_W-1:0]  modulus_words [NUM_CFG];
  logic [WORD_W-1:0] operand_words [NUM_WORDS];
  int                words_loaded;

  result_word_t inverse_words_due [$];

  int failures;
  int operands_done;
  int words_checked;
  int modulus_loads;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_left;

  binary_modular_inverse_unit dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .out_last  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs. The slowest legal run (every word flagged, every
  // inverse running to its iteration bound, long receiver stalls) stays well inside this.
  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------

  // Halves a coefficient modulo m. An odd coefficient has m added first, and the carry
  // out of that sum becomes the new top bit.
  function automatic big_t halve_mod(big_t c, big_t m);
    logic [BIG_W:0] sum;
    if (c[0]) begin
      sum = {1'b0, c} + {1'b0, m};
      return sum[BIG_W:1];
    end
    return c >> 1;
  endfunction

  // x - y modulo m, then halved modulo m.
  function automatic big_t halve_mod_diff(big_t x, big_t y, big_t m);
    big_t d;
    d = x;
    if (d < y) d = d + m;
    d = d - y;
    return halve_mod(d, m);
  endfunction

  function automatic big_t binary_inverse(big_t operand, big_t m);
    big_t a;
    big_t b;
    big_t u;
    big_t v;
    int   iter;
    if (operand == NO_BIG) return NO_BIG;
    a = operand;
    b = m;
    u = BIG_ONE;
    v = NO_BIG;
    iter = 0;
    // The bound only matters with a zero modulus; otherwise a meets b much sooner.
    while (iter < MAX_ITER && a != b) begin
      if (!a[0]) begin
        a = a >> 1;
        u = halve_mod(u, m);
      end else if (!b[0]) begin
        b = b >> 1;
        v = halve_mod(v, m);
      end else if (a > b) begin
        a = (a - b) >> 1;
        u = halve_mod_diff(u, v, m);
      end else begin
        b = (b - a) >> 1;
        v = halve_mod_diff(v, u, m);
      end
      iter++;
    end
    return u;
  endfunction

  // Takes one accepted operand word. Returns 1 with the inverse when the word is flagged.
  function automatic bit take_operand_word(input logic [WORD_W-1:0] w, input logic flag,
                                           output big_t inv);
    big_t operand;
    big_t m;
    int   k;
    inv = NO_BIG;
    if (words_loaded < NUM_WORDS) begin
      operand_words[words_loaded] = w;
      words_loaded++;
    end
    if (!flag) return 1'b0;
    for (k = words_loaded; k < NUM_WORDS; k++) operand_words[k] = '0;
    for (k = 0; k < NUM_WORDS; k++) begin
      operand[k*WORD_W +: WORD_W] = operand_words[k];
      m[k*WORD_W +: WORD_W] = modulus_words[k % NUM_CFG];
    end
    inv = binary_inverse(operand, m);
    words_loaded = 0;
    return 1'b1;
  endfunction

  function automatic big_t random_big(int nbits);
    big_t r;
    int   k;
    for (k = 0; k < BIG_W / 32; k++) r[k*32 +: 32] = $urandom;
    if (nbits < BIG_W) r &= (big_t'(1) << nbits) - big_t'(1);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------

  task automatic note_failure(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (failures < 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    failures++;
  endtask

  // Everything is sampled at the rising edge, before the block's own updates land. An
  // accepted flagged request queues four expected result words; each accepted result
  // request is compared with the oldest of them.
  always @(posedge clk) begin : check_traffic
    big_t         inv;
    result_word_t due;
    int           k;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (take_operand_word(in_word, in_last, inv)) begin
          if (offer_typed) inv = offer_inverse;
          for (k = 0; k < NUM_WORDS; k++) begin
            due.word = inv[k*WORD_W +: WORD_W];
            due.last = (k == NUM_WORDS - 1);
            inverse_words_due.push_back(due);
          end
          operands_done++;
        end
      end
      if (out_valid && !out_stall) begin
        words_checked++;
        if (inverse_words_due.size() == 0) begin
          note_failure("unexpected result word", '0, out_word);
        end else begin
          due = inverse_words_due.pop_front();
          if (out_word !== due.word) note_failure("out_word", due.word, out_word);
          if (out_last !== due.last)
            note_failure("out_last", WORD_W'(due.last), WORD_W'(out_last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here, during which the
  // sender keeps offering requests and the block has to hold its input off.
  // ---------------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_left > 0) begin
        out_stall <= 1'b1;
        recv_hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Sender tasks. They are entered just after a falling edge and return just after one.
  // ---------------------------------------------------------------------------------

  // Offers one operand word and waits until it is taken. Valid is left high on return,
  // so that back-to-back requests need no gap; a pause must lower it explicitly.
  task automatic offer_word(logic [WORD_W-1:0] w, logic flag, logic typed, big_t inv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_word       <= w;
    in_last       <= flag;
    offer_typed   <= typed;
    offer_inverse <= inv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected result word has been seen, then lets
  // the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (inverse_words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four modulus registers over the configuration port, with the block idle.
  task automatic load_modulus(big_t m);
    int i;
    drain_results();
    for (i = 0; i < NUM_CFG; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(i * 8);
      pwdata  <= m[i*CFG_W +: CFG_W];
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      modulus_words[i] = m[i*CFG_W +: CFG_W];
      @(negedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    modulus_loads++;
  endtask

  // ---------------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then three random phases with different
  // idling, each made of segments that start with a fresh modulus.
  // ---------------------------------------------------------------------------------
  initial begin : stimulus
    int                r;
    int                phase;
    int                seg;
    int                seg_words;
    int                nwords;
    int                k;
    int                shape;
    int                width;
    big_t              modv;
    big_t              value;
    logic [WORD_W-1:0] w;

    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_word       = '0;
    in_last       = 1'b0;
    offer_typed   = 1'b0;
    offer_inverse = NO_BIG;
    for (k = 0; k < NUM_CFG; k++) modulus_words[k] = '0;
    words_loaded   = 0;
    failures       = 0;
    operands_done  = 0;
    words_checked  = 0;
    modulus_loads  = 0;
    recv_hold_left = 0;
    send_idle_pct  = 24;
    recv_idle_pct  = 51;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].set_mod) load_modulus(dir_table[r].mod_value);
      offer_word(dir_table[r].word, dir_table[r].last, dir_table[r].typed,
                 dir_table[r].inverse);
    end

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 24 : 0;
      for (seg = 0; seg < 4; seg++) begin
        // Mostly odd moduli of every width; now and then zero, all ones or even.
        shape = $urandom_range(0, 11);
        if (shape == 0) begin
          modv = NO_BIG;
        end else if (shape == 1) begin
          modv = ALL_ONES;
        end else if (shape == 2) begin
          modv = random_big($urandom_range(2, BIG_W));
          modv[0] = 1'b0;
        end else begin
          width = (shape < 6) ? $urandom_range(2, WORD_W) : $urandom_range(WORD_W + 1, BIG_W);
          modv = random_big(width);
          modv[0] = 1'b1;
          modv[width-1] = 1'b1;
        end
        load_modulus(modv);

        // Once, the receiver holds off for a long stretch while requests keep coming.
        if (phase == 0 && seg == 1) recv_hold_left = LONG_HOLD;

        seg_words = 0;
        while (seg_words < SEG_WORDS) begin
          // Mostly full four-word operands below the modulus; some zero, short or
          // over-long operands mixed in.
          shape = $urandom_range(0, 9);
          value = random_big($urandom_range(1, BIG_W));
          if (modv != NO_BIG) value = value % modv;
          if (shape == 0) value = NO_BIG;
          nwords = (shape == 1) ? $urandom_range(1, NUM_WORDS - 1) :
                   (shape == 2) ? $urandom_range(NUM_WORDS + 1, NUM_WORDS + 3) : NUM_WORDS;
          for (k = 0; k < nwords; k++) begin
            w = (k < NUM_WORDS) ? value[(k % NUM_WORDS)*WORD_W +: WORD_W]
                                : {$urandom, $urandom};
            offer_word(w, (k == nwords - 1), 1'b0, NO_BIG);
          end
          seg_words += (nwords < NUM_WORDS) ? nwords : NUM_WORDS;
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run covered %0d operands under %0d modulus settings, with short, over-long,",
             operands_done, modulus_loads);
    $display("zero and out-of-range operands; %0d result words checked, %0d failures.",
             words_checked, failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
